>>> hw/rtl/dei_pkg.sv
// Types and constants shared by the drive-enable interlock block.
package dei_pkg;

  // Field widths
  localparam int unsigned CountW   = 16;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned StepW    = 8;
  localparam int unsigned VsmW     = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP    = 1'd1;

  // Reset values
  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [StepW-1:0]    STEP_RESET    = 8'd10;
  localparam logic [TimerW-1:0]   TIMER_MAX     = '1;

  // Inverter state codes that count as ready
  localparam logic [VsmW-1:0] VSM_READY   = 8'd5;
  localparam logic [VsmW-1:0] VSM_RUNNING = 8'd6;

  typedef enum logic [2:0] {
    ST_DISCONNECTED = 3'd0,
    ST_DISABLED     = 3'd1,
    ST_UNLOCKING    = 3'd2,
    ST_ENABLED      = 3'd3,
    ST_READY        = 3'd4
  } state_t;

  // One control tick
  typedef struct packed {
    logic [CountW-1:0] msg_count;
    logic              inverter_enabled;
    logic [VsmW-1:0]   vsm_code;
    logic              brake_on;
    logic              button_pressed;
  } in_t;

  // One result
  typedef struct packed {
    logic [2:0] fsm_state;
    logic       enable_request;
    logic       drive_ready;
    logic       link_alive;
  } out_t;

  // Updated state handed back from the step logic
  typedef struct packed {
    state_t            state_next;
    logic [TimerW-1:0] timer_next;
  } step_t;

endpackage

>>> hw/rtl/drive_enable_interlock_fsm_core.sv
// Top level of the drive-enable interlock: input register, step logic, result register.
//
// Each request is one control tick; the block returns exactly one result per tick,
// giving the interlock state after the step, the inverter enable request, the
// drive-ready flag and whether the inverter link is alive. A request is taken every
// clock cycle while the input register is empty or the result register is free. The
// request is captured in the input register, and its result is loaded into the result
// register when that is free. The rate is set by the loop through the state, silence
// timer and previous-count registers. A new request is accepted while a finished
// result still waits in the result register, as long as the input register is empty.
// After reset the timer is saturated, so the link counts as lost until a message count
// change is seen. Configuration (timeout_ms at index 0, step_ms at index 1) is to be
// written only while the block is idle.
module drive_enable_interlock_fsm_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dei_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dei_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [dei_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [dei_pkg::CfgDataW-1:0]   cfg_data
);

  logic [dei_pkg::TimeoutW-1:0] timeout_ms;
  logic [dei_pkg::StepW-1:0]    step_ms;
  dei_pkg::state_t              state;
  logic [dei_pkg::TimerW-1:0]   timer;
  logic [dei_pkg::CountW-1:0]   prev_count;
  logic                         s1_valid;
  dei_pkg::in_t                 s1_data;
  logic                         out_free;
  logic                         advance;
  dei_pkg::step_t               upd;
  dei_pkg::out_t                result;

  // Handshake: the result register frees up when empty or being taken
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= dei_pkg::TIMEOUT_RESET;
      step_ms    <= dei_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dei_pkg::CFG_TIMEOUT: timeout_ms <= cfg_data[dei_pkg::TimeoutW-1:0];
        dei_pkg::CFG_STEP:    step_ms    <= cfg_data[dei_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  dei_step u_step (
    .tick       (s1_data),
    .state      (state),
    .timer      (timer),
    .prev_count (prev_count),
    .timeout_ms (timeout_ms),
    .step_ms    (step_ms),
    .upd        (upd),
    .result     (result)
  );

  // Interlock state, silence timer and last count: advance with each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dei_pkg::ST_DISCONNECTED;
      timer      <= dei_pkg::TIMER_MAX;
      prev_count <= '0;
    end else if (advance) begin
      state      <= upd.state_next;
      timer      <= upd.timer_next;
      prev_count <= s1_data.msg_count;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // Drive-ready always comes with the enable request
  a_ready_implies_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.drive_ready || out_data.enable_request))
    else $error("drive_ready without enable_request");

  // A lost link always reports the disconnected state
  a_lost_disconnected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.link_alive) |-> (out_data.fsm_state == dei_pkg::ST_DISCONNECTED))
    else $error("link lost but state not disconnected");

  // The reported state matches the state register after each step
  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_data.fsm_state == state))
    else $error("result state differs from state register");

  // A changed message count clears the silence timer
  a_timer_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_data.msg_count != prev_count)) |=> (timer == '0))
    else $error("silence timer not cleared on new message");

endmodule

>>> hw/rtl/dei_step.sv
// Combinational step of the interlock: silence timer, link check and next state.
module dei_step (
  input  dei_pkg::in_t                      tick,
  input  dei_pkg::state_t                   state,
  input  logic [dei_pkg::TimerW-1:0]        timer,
  input  logic [dei_pkg::CountW-1:0]        prev_count,
  input  logic [dei_pkg::TimeoutW-1:0]      timeout_ms,
  input  logic [dei_pkg::StepW-1:0]         step_ms,
  output dei_pkg::step_t                    upd,
  output dei_pkg::out_t                     result
);

  logic [dei_pkg::TimerW:0]   timer_sum;
  logic [dei_pkg::TimerW-1:0] timer_new;
  logic                       alive;
  logic                       inv_en;
  logic                       inv_rdy;
  logic                       brake;
  logic                       button;
  dei_pkg::state_t            state_next;

  // Advance the silence timer with saturation, or clear it on a new message
  assign timer_sum = {1'b0, timer} + {{(dei_pkg::TimerW + 1 - dei_pkg::StepW){1'b0}}, step_ms};

  always_comb begin
    if (tick.msg_count == prev_count) begin
      if (timer_sum[dei_pkg::TimerW]) begin
        timer_new = dei_pkg::TIMER_MAX;
      end else begin
        timer_new = timer_sum[dei_pkg::TimerW-1:0];
      end
    end else begin
      timer_new = '0;
    end
  end

  assign alive = (timer_new < timeout_ms);

  // With the link lost, take the inverter as enabled and not ready
  assign inv_en  = alive ? tick.inverter_enabled : 1'b1;
  assign inv_rdy = alive && ((tick.vsm_code == dei_pkg::VSM_READY) ||
                             (tick.vsm_code == dei_pkg::VSM_RUNNING));
  assign brake   = tick.brake_on;
  assign button  = tick.button_pressed;

  // Next state: first matching condition wins
  always_comb begin
    state_next = dei_pkg::ST_DISCONNECTED;
    case (state)
      dei_pkg::ST_DISCONNECTED: begin
        state_next = alive ? dei_pkg::ST_DISABLED : dei_pkg::ST_DISCONNECTED;
      end
      dei_pkg::ST_DISABLED: begin
        if (!alive) state_next = dei_pkg::ST_DISCONNECTED;
        else if (brake && button) state_next = dei_pkg::ST_UNLOCKING;
        else state_next = dei_pkg::ST_DISABLED;
      end
      dei_pkg::ST_UNLOCKING: begin
        if (!alive) state_next = dei_pkg::ST_DISCONNECTED;
        else if (!brake || !button) state_next = dei_pkg::ST_DISABLED;
        else if (inv_en) state_next = dei_pkg::ST_ENABLED;
        else state_next = dei_pkg::ST_UNLOCKING;
      end
      dei_pkg::ST_ENABLED: begin
        if (!alive) state_next = dei_pkg::ST_DISCONNECTED;
        else if (!inv_en) state_next = dei_pkg::ST_DISABLED;
        else if (inv_rdy) state_next = dei_pkg::ST_READY;
        else state_next = dei_pkg::ST_ENABLED;
      end
      dei_pkg::ST_READY: begin
        if (!alive) state_next = dei_pkg::ST_DISCONNECTED;
        else if (!inv_rdy) state_next = dei_pkg::ST_ENABLED;
        else if (!inv_en) state_next = dei_pkg::ST_DISABLED;
        else state_next = dei_pkg::ST_READY;
      end
      default: begin
        state_next = dei_pkg::ST_DISCONNECTED;
      end
    endcase
  end

  // Outputs decoded from the new state, with the link flag and the updated timer passed through
  always_comb begin
    upd.state_next        = state_next;
    upd.timer_next        = timer_new;
    result.fsm_state      = state_next;
    result.enable_request = (state_next == dei_pkg::ST_UNLOCKING) ||
                            (state_next == dei_pkg::ST_ENABLED) ||
                            (state_next == dei_pkg::ST_READY);
    result.drive_ready    = (state_next == dei_pkg::ST_READY);
    result.link_alive     = alive;
  end

endmodule

>>> bench/tb_drive_enable_interlock_fsm_core.sv
// Self-checking bench for the drive-enable interlock core: directed table, random ticks.
`timescale 1ns / 1ps

module tb_drive_enable_interlock_fsm_core;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 90;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_KNOWN,
    ROW_CFG
  } row_kind_t;

  // One line of the directed table: a tick, a tick with a fixed answer, or a register write
  typedef struct packed {
    row_kind_t                      kind;
    dei_pkg::in_t                   tick;
    dei_pkg::out_t                  want;
    logic [dei_pkg::CfgIdxW-1:0]    idx;
    logic [dei_pkg::CfgDataW-1:0]   val;
  } row_t;

  typedef struct packed {
    logic [dei_pkg::TimeoutW-1:0] timeout;
    logic [dei_pkg::StepW-1:0]    step;
    logic [11:0]                  items;
  } phase_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  dei_pkg::in_t                 in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  dei_pkg::out_t                out_data;
  logic                         cfg_we = 1'b0;
  logic [dei_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [dei_pkg::CfgDataW-1:0] cfg_data = '0;

  // Shadow of the block's registers and state
  logic [dei_pkg::TimeoutW-1:0] cur_timeout = dei_pkg::TIMEOUT_RESET;
  logic [dei_pkg::StepW-1:0]    cur_step = dei_pkg::STEP_RESET;
  dei_pkg::state_t              interlock = dei_pkg::ST_DISCONNECTED;
  logic [dei_pkg::TimerW-1:0]   silence = dei_pkg::TIMER_MAX;
  logic [dei_pkg::CountW-1:0]   last_count = '0;

  dei_pkg::out_t              pending_status[$];
  int unsigned                mismatches = 0;
  int unsigned                cycle_count = 0;
  int unsigned                burst_left = 0;
  int unsigned                silence_left = 0;
  logic [dei_pkg::CountW-1:0] run_count = '0;
  logic                       hold_wanted = 1'b0;

  row_t   directed[$];
  phase_t phases[8];

  drive_enable_interlock_fsm_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Outputs implied by a state and the link flag
  function automatic dei_pkg::out_t status(dei_pkg::state_t st, logic alive);
    dei_pkg::out_t s;
    s.fsm_state      = st;
    s.enable_request = (st == dei_pkg::ST_UNLOCKING) || (st == dei_pkg::ST_ENABLED) ||
                       (st == dei_pkg::ST_READY);
    s.drive_ready    = (st == dei_pkg::ST_READY);
    s.link_alive     = alive;
    return s;
  endfunction

  // Advance the shadow interlock by one tick and return its outputs
  function automatic dei_pkg::out_t step_interlock(dei_pkg::in_t t);
    logic [dei_pkg::TimerW:0] sum;
    logic                     alive;
    logic                     en;
    logic                     rdy;
    dei_pkg::state_t          nxt;
    if (t.msg_count == last_count) begin
      sum     = {1'b0, silence} + (dei_pkg::TimerW + 1)'(cur_step);
      silence = sum[dei_pkg::TimerW] ? dei_pkg::TIMER_MAX : sum[dei_pkg::TimerW-1:0];
    end else begin
      silence = '0;
    end
    last_count = t.msg_count;
    alive = silence < cur_timeout;
    // A lost link reads as enabled and not ready
    en  = alive ? t.inverter_enabled : 1'b1;
    rdy = alive && ((t.vsm_code == dei_pkg::VSM_READY) ||
                    (t.vsm_code == dei_pkg::VSM_RUNNING));
    nxt = interlock;
    case (interlock)
      dei_pkg::ST_DISCONNECTED: begin
        if (alive) nxt = dei_pkg::ST_DISABLED;
      end
      dei_pkg::ST_DISABLED: begin
        if (!alive) nxt = dei_pkg::ST_DISCONNECTED;
        else if (t.brake_on && t.button_pressed) nxt = dei_pkg::ST_UNLOCKING;
      end
      dei_pkg::ST_UNLOCKING: begin
        if (!alive) nxt = dei_pkg::ST_DISCONNECTED;
        else if (!(t.brake_on && t.button_pressed)) nxt = dei_pkg::ST_DISABLED;
        else if (en) nxt = dei_pkg::ST_ENABLED;
      end
      dei_pkg::ST_ENABLED: begin
        if (!alive) nxt = dei_pkg::ST_DISCONNECTED;
        else if (!en) nxt = dei_pkg::ST_DISABLED;
        else if (rdy) nxt = dei_pkg::ST_READY;
      end
      dei_pkg::ST_READY: begin
        if (!alive) nxt = dei_pkg::ST_DISCONNECTED;
        else if (!rdy) nxt = dei_pkg::ST_ENABLED;
        else if (!en) nxt = dei_pkg::ST_DISABLED;
      end
      default: begin
        nxt = dei_pkg::ST_DISCONNECTED;
      end
    endcase
    interlock = nxt;
    return status(nxt, alive);
  endfunction

  function automatic row_t tick_row(logic [dei_pkg::CountW-1:0] cnt, logic en,
                                    logic [dei_pkg::VsmW-1:0] vsm, logic brk, logic btn);
    row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.tick = '{msg_count: cnt, inverter_enabled: en, vsm_code: vsm,
               brake_on: brk, button_pressed: btn};
    return r;
  endfunction

  function automatic row_t known_row(logic [dei_pkg::CountW-1:0] cnt, logic en,
                                     logic [dei_pkg::VsmW-1:0] vsm, logic brk, logic btn,
                                     dei_pkg::out_t want);
    row_t r;
    r      = tick_row(cnt, en, vsm, brk, btn);
    r.kind = ROW_KNOWN;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [dei_pkg::CfgIdxW-1:0] idx,
                                   logic [dei_pkg::CfgDataW-1:0] val);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // Mostly a live link with pedals and inverter cooperating; some silence and some noise
  function automatic dei_pkg::in_t random_tick();
    dei_pkg::in_t t;
    int           roll;
    roll = $urandom_range(0, 99);
    if (silence_left > 0) begin
      silence_left--;
    end else if (roll < 3) begin
      silence_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
    end else if (roll < 8) begin
      run_count = dei_pkg::CountW'($urandom());
    end else begin
      run_count++;
    end
    t.msg_count = run_count;
    if ($urandom_range(0, 4) == 0) begin
      t.inverter_enabled = 1'($urandom());
      t.vsm_code         = dei_pkg::VsmW'($urandom());
      t.brake_on         = 1'($urandom());
      t.button_pressed   = 1'($urandom());
    end else begin
      t.inverter_enabled = ($urandom_range(0, 6) != 0);
      t.brake_on         = ($urandom_range(0, 9) != 0);
      t.button_pressed   = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) < 7) begin
        t.vsm_code = $urandom_range(0, 1) ? dei_pkg::VSM_READY : dei_pkg::VSM_RUNNING;
      end else begin
        t.vsm_code = dei_pkg::VsmW'($urandom());
      end
    end
    return t;
  endfunction

  // Offer one request, hold it until taken, then record what should come back
  task automatic offer(input dei_pkg::in_t t, input logic known, input dei_pkg::out_t want);
    dei_pkg::out_t pred;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    pred = step_interlock(t);
    pending_status.push_back(known ? want : pred);
    // End the burst with a gap of random length
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dei_pkg::CfgIdxW-1:0] idx,
                           input logic [dei_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == dei_pkg::CFG_TIMEOUT) cur_timeout = val[dei_pkg::TimeoutW-1:0];
    else if (idx == dei_pkg::CFG_STEP) cur_step = val[dei_pkg::StepW-1:0];
  endtask

  // Receiver: segments of steady, light and heavy stalling, plus a long hold-off on request
  initial begin
    int unsigned seg_left;
    int unsigned seg_mode;
    seg_left = 0;
    seg_mode = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_wanted = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (seg_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    dei_pkg::out_t exp_s;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("unexpected result: fsm_state %0d", out_data.fsm_state);
        mismatches++;
      end else begin
        exp_s = pending_status.pop_front();
        if (out_data.fsm_state !== exp_s.fsm_state) begin
          $error("fsm_state: expected %0d, got %0d", exp_s.fsm_state, out_data.fsm_state);
          mismatches++;
        end
        if (out_data.enable_request !== exp_s.enable_request) begin
          $error("enable_request: expected %0d, got %0d",
                 exp_s.enable_request, out_data.enable_request);
          mismatches++;
        end
        if (out_data.drive_ready !== exp_s.drive_ready) begin
          $error("drive_ready: expected %0d, got %0d", exp_s.drive_ready, out_data.drive_ready);
          mismatches++;
        end
        if (out_data.link_alive !== exp_s.link_alive) begin
          $error("link_alive: expected %0d, got %0d", exp_s.link_alive, out_data.link_alive);
          mismatches++;
        end
      end
    end
  end

  initial begin
    // Walk the interlock up to ready and back, then the timeout and step extremes
    directed.push_back(known_row(16'd0, 1'b0, 8'd0, 1'b0, 1'b0,
                                 status(dei_pkg::ST_DISCONNECTED, 1'b0)));
    directed.push_back(known_row(16'd1, 1'b0, 8'd0, 1'b0, 1'b0,
                                 status(dei_pkg::ST_DISABLED, 1'b1)));
    directed.push_back(tick_row(16'd2, 1'b0, 8'd0, 1'b1, 1'b1));
    directed.push_back(tick_row(16'd3, 1'b0, 8'h80, 1'b1, 1'b1));
    directed.push_back(tick_row(16'd4, 1'b1, 8'd0, 1'b1, 1'b1));
    directed.push_back(tick_row(16'd5, 1'b1, dei_pkg::VSM_READY, 1'b0, 1'b0));
    directed.push_back(tick_row(16'd6, 1'b1, dei_pkg::VSM_RUNNING, 1'b0, 1'b0));
    directed.push_back(tick_row(16'd7, 1'b1, 8'd7, 1'b0, 1'b0));
    directed.push_back(tick_row(16'd8, 1'b1, dei_pkg::VSM_RUNNING, 1'b0, 1'b1));
    directed.push_back(tick_row(16'd9, 1'b0, dei_pkg::VSM_READY, 1'b1, 1'b0));
    directed.push_back(tick_row(16'hFFFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    directed.push_back(tick_row(16'hFFFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    directed.push_back(cfg_row(dei_pkg::CFG_TIMEOUT, 16'd15));
    directed.push_back(known_row(16'hFFFF, 1'b1, dei_pkg::VSM_READY, 1'b1, 1'b1,
                                 status(dei_pkg::ST_DISCONNECTED, 1'b0)));
    directed.push_back(tick_row(16'd0, 1'b0, 8'd0, 1'b0, 1'b0));
    // Zero step: the timer stands still while the count is unchanged
    directed.push_back(cfg_row(dei_pkg::CFG_STEP, 16'd0));
    directed.push_back(tick_row(16'd0, 1'b0, 8'd0, 1'b1, 1'b1));
    directed.push_back(tick_row(16'd0, 1'b1, 8'd0, 1'b1, 1'b1));
    directed.push_back(cfg_row(dei_pkg::CFG_STEP, 16'd255));
    directed.push_back(known_row(16'd0, 1'b1, dei_pkg::VSM_READY, 1'b1, 1'b1,
                                 status(dei_pkg::ST_DISCONNECTED, 1'b0)));
    // Zero timeout: the link never comes up
    directed.push_back(cfg_row(dei_pkg::CFG_TIMEOUT, 16'd0));
    directed.push_back(known_row(16'd1, 1'b1, dei_pkg::VSM_READY, 1'b1, 1'b1,
                                 status(dei_pkg::ST_DISCONNECTED, 1'b0)));
    directed.push_back(cfg_row(dei_pkg::CFG_TIMEOUT, 16'hFFFF));
    directed.push_back(tick_row(16'd2, 1'b1, dei_pkg::VSM_RUNNING, 1'b1, 1'b1));

    phases = '{
      '{timeout: 16'd500,   step: 8'd10,  items: 12'd180},
      '{timeout: 16'd40,    step: 8'd7,   items: 12'd180},
      '{timeout: 16'hFFFF,  step: 8'd255, items: 12'd400},
      '{timeout: 16'd1,     step: 8'd1,   items: 12'd130},
      '{timeout: 16'd300,   step: 8'd0,   items: 12'd150},
      '{timeout: 16'd0,     step: 8'd3,   items: 12'd80},
      '{timeout: 16'd1000,  step: 8'd200, items: 12'd200},
      '{timeout: 16'd25,    step: 8'd5,   items: 12'd210}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(directed[i].idx, directed[i].val);
        end
        ROW_KNOWN: offer(directed[i].tick, 1'b1, directed[i].want);
        default:   offer(directed[i].tick, 1'b0, '0);
      endcase
    end

    // Random ticks under a range of register settings
    foreach (phases[p]) begin
      drain();
      write_reg(dei_pkg::CFG_TIMEOUT, dei_pkg::CfgDataW'(phases[p].timeout));
      write_reg(dei_pkg::CFG_STEP, dei_pkg::CfgDataW'(phases[p].step));
      if (p == 1 || p == 6) hold_wanted = 1'b1;
      repeat (phases[p].items) offer(random_tick(), 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
